// ----- hw/rtl/modpow_pkg.sv -----
// modpow_pkg: shared types and constants for the modular_power block.
// No dependencies.
`timescale 1ns / 1ps
package modpow_pkg;
    localparam int unsigned MOD_W  = 31;
    localparam int unsigned BASE_W = 32;
    localparam int unsigned EXP_W  = 63;
    localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

    typedef logic [MOD_W-1:0] t_mod;

    // start/operand bundle into the serial modular multiplier
    typedef struct packed {
        logic start;
        t_mod a;
        t_mod b;
    } t_mul_req;
endpackage

// ----- hw/rtl/modular_power.sv -----
// modular_power: top level, base^exponent mod modulus by square-and-multiply.
// Uses modpow_pkg, modpow_reduce, modpow_mulmod.
`timescale 1ns / 1ps
// Channel  Dir  Handshake        Payload
// in       in   valid / stall    i_base_value[31:0], i_exponent[62:0]
// out      out  valid / stall    o_power_result[30:0]
// cfg      in   valid / ready    i_cfg_data[30:0] (modulus)
//
// Sequence: a transaction first reduces the base mod m, then,
// per exponent bit up to the top set bit, does one squaring and, for a set bit,
// one multiply, each in the single bit-serial multiplier.
// Worst case, all 63 exponent bits set: 125 products.
// Reset (synchronous, active low) restores modulus 1000000007 and idles.
// The result register holds while o_out stall is high; input is taken
// only when idle and the result register is free.
module modular_power (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_base_value,
    input  logic [62:0] i_exponent,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [30:0] o_power_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data
);
    import modpow_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_MUL  = 5'b00100,
        S_SQR  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state            r_state;
    t_mod              r_mod;
    t_mod              r_acc;
    t_mod              r_base;
    logic [EXP_W-1:0]  r_exp;
    logic              r_out_valid;
    t_mod              r_res;
    logic              r_wait;   // multiplier launched, waiting for done

    logic              in_acc;
    logic              red_start, red_done;
    t_mod              red_rem;
    t_mul_req          mul_req;
    logic              mul_done;
    t_mod              mul_prod;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE) || r_out_valid;
    assign o_cfg_ready = 1'b1;
    assign red_start   = in_acc && (i_exponent != '0) && (r_mod != '0);

    modpow_reduce u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (red_start),
        .i_value (i_base_value),
        .i_mod   (r_mod),
        .o_done  (red_done),
        .o_rem   (red_rem)
    );

    // no squaring is launched once the remaining exponent is used up
    always_comb begin
        mul_req.start = 1'b0;
        mul_req.a     = r_base;
        mul_req.b     = r_base;
        if (r_state == S_MUL) begin
            mul_req.a     = r_acc;
            mul_req.start = !r_wait;
        end else if (r_state == S_SQR) begin
            mul_req.start = !r_wait && (r_exp[EXP_W-1:1] != '0);
        end
    end

    modpow_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_mod   (r_mod),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mod       <= MOD_RESET;
            r_out_valid <= 1'b0;
            r_wait      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mod <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (r_mod == '0) begin
                            r_res       <= '0;
                            r_out_valid <= 1'b1;
                        end else if (i_exponent == '0) begin
                            r_res       <= MOD_W'(1);
                            r_out_valid <= 1'b1;
                        end else begin
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (red_done) begin
                        r_base  <= red_rem;
                        // acc = 1 mod m (0 when m is 1)
                        r_acc   <= (r_mod == MOD_W'(1)) ? '0 : MOD_W'(1);
                        r_state <= r_exp[0] ? S_MUL : S_SQR;
                    end
                end
                S_MUL: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_acc   <= mul_prod;
                        r_wait  <= 1'b0;
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    if (r_exp[EXP_W-1:1] == '0) begin
                        r_wait      <= 1'b0;
                        r_res       <= r_acc;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_base  <= mul_prod;
                        r_wait  <= 1'b0;
                        r_exp   <= {1'b0, r_exp[EXP_W-1:1]};
                        r_state <= r_exp[1] ? S_MUL : S_SQR;
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (in_acc) begin
            r_exp <= i_exponent;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_power_result = r_res;
endmodule

// ----- hw/rtl/modpow_mulmod.sv -----
// modpow_mulmod: bit-serial modular multiplier, (a*b) mod m, MSB first.
// One bit of b per cycle; needs a, b < m. Depends on modpow_pkg.
`timescale 1ns / 1ps
module modpow_mulmod (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  modpow_pkg::t_mul_req  i_req,
    input  modpow_pkg::t_mod      i_mod,
    output logic                  o_done,
    output modpow_pkg::t_mod      o_prod
);
    import modpow_pkg::*;

    localparam int unsigned CNT_W = $clog2(MOD_W + 1);

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_mod             r_acc, n_acc;
    t_mod             r_a, n_a;
    t_mod             r_b, n_b;
    logic             r_done, n_done;

    logic [MOD_W:0] dbl, dbl_r, add, add_r;

    always_comb begin
        dbl   = {r_acc, 1'b0};
        dbl_r = (dbl >= {1'b0, i_mod}) ? dbl - {1'b0, i_mod} : dbl;
        add   = dbl_r + {1'b0, r_a};
        add_r = (add >= {1'b0, i_mod}) ? add - {1'b0, i_mod} : add;
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(MOD_W);
            n_acc  = '0;
            n_a    = i_req.a;
            n_b    = i_req.b;
        end else if (r_busy) begin
            n_acc = r_b[MOD_W-1] ? add_r[MOD_W-1:0] : dbl_r[MOD_W-1:0];
            n_b   = {r_b[MOD_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ----- hw/rtl/modpow_reduce.sv -----
// modpow_reduce: bit-serial restoring reduction of a 32-bit base mod m.
// One base bit per cycle, MSB first. Depends on modpow_pkg.
`timescale 1ns / 1ps
module modpow_reduce (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [modpow_pkg::BASE_W-1:0] i_value,
    input  modpow_pkg::t_mod            i_mod,
    output logic                        o_done,
    output modpow_pkg::t_mod            o_rem
);
    import modpow_pkg::*;

    localparam int unsigned CNT_W = $clog2(BASE_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [BASE_W-1:0] r_val;
    t_mod              r_rem;
    logic [MOD_W:0]    sh, sub;

    always_comb begin
        sh  = {r_rem, r_val[BASE_W-1]};
        sub = (sh >= {1'b0, i_mod}) ? sh - {1'b0, i_mod} : sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(BASE_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_val <= i_value;
            r_rem <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[BASE_W-2:0], 1'b0};
            r_rem <= sub[MOD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// ----- tb/sv/modular_power_checker.sv -----
// modular_power_checker: watches the in/out/cfg channels of modular_power,
// predicts each power result and compares it with what the block returns.
// Uses modpow_pkg for widths and the modulus reset value.
`timescale 1ns / 1ps
module modular_power_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [31:0]      i_base_value,
    input  logic [62:0]      i_exponent,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [30:0]      i_power_result,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [30:0]      i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);
    import modpow_pkg::*;

    t_mod modulus_q;
    t_mod expected_powers[$];

    function automatic t_mod power_mod(logic [31:0] b_in, logic [62:0] e_in, t_mod m);
        logic [63:0] acc;
        logic [63:0] b;
        logic [62:0] e;
        acc = 64'd1;
        b   = 64'(b_in);
        e   = e_in;
        if (m == '0) return '0;
        if (e == '0) return t_mod'(1);
        b = b % 64'(m);
        while (e != '0) begin
            if (e[0]) acc = (acc * b) % 64'(m);
            b = (b * b) % 64'(m);
            e = e >> 1;
        end
        return t_mod'(acc);
    endfunction

    assign o_pending = expected_powers.size();

    always @(posedge i_clk) begin
        t_mod want;
        if (!i_rst_n) begin
            modulus_q <= MOD_RESET;
            expected_powers.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) modulus_q <= i_cfg_data;
            if (i_in_valid && !i_in_stall)
                expected_powers.push_back(power_mod(i_base_value, i_exponent, modulus_q));
            if (i_out_valid && !i_out_stall) begin
                if (expected_powers.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("power_result: expected none got %0d", i_power_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_powers.pop_front();
                    if (want !== i_power_result) begin
                        if (o_fail_count < 10)
                            $display("power_result: expected %0d got %0d",
                                     want, i_power_result);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/sv/modular_power_tb.sv -----
// modular_power_tb: stimulus and verdict for modular_power.
// Depends on modpow_pkg, modular_power and modular_power_checker.
`timescale 1ns / 1ps
module modular_power_tb;
    import modpow_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] base_value = '0;
    logic [62:0] exponent = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [30:0] power_result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [30:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    bit          idle_off = 1'b0;   // no idling in the closing stretch
    bit          hold_req = 1'b0;   // receiver long hold-off request

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    modular_power u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_base_value(base_value), .i_exponent(exponent),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_power_result(power_result),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    modular_power_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_base_value(base_value), .i_exponent(exponent),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_power_result(power_result),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: random stall bursts, plus one long hold-off on request so
    // the result register fills and the block pushes back on its input.
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (3000) @(negedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 9);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one transaction; valid stays up while stalled, payload holds.
    task automatic send_power(logic [31:0] b, logic [62:0] e);
        int n;
        if (!idle_off && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            n = $urandom_range(1, 9);
            repeat (n) @(negedge clk);
        end
        in_valid   <= 1'b1;
        base_value <= b;
        exponent   <= e;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Modulus write while idle: drain results, let the block settle.
    task automatic write_modulus(logic [30:0] m);
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random exponent: mostly short so runs stay quick, a few full width.
    function automatic logic [62:0] rand_exponent();
        logic [62:0] e;
        e = 63'({$urandom, $urandom});
        case ($urandom_range(0, 9))
            0:       return e;
            1:       return '0;
            default: return e >> $urandom_range(40, 62);
        endcase
    endfunction

    function automatic logic [31:0] rand_base();
        case ($urandom_range(0, 5))
            0:       return '1;
            1:       return 32'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [30:0] moduli[6];
        moduli = '{31'd1, 31'h7FFF_FFFF, 31'd2, 31'd1000000007, 31'd97, 31'h7FFF_FFED};
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset modulus, field extremes, exponent zero.
        send_power('0, '0);
        send_power('1, '0);
        send_power('1, '1);
        send_power(32'd2, 63'd10);
        send_power(32'h5555_AAAA, 63'h2AAA_AAAA_AAAA_AAAA);
        send_power(32'hAAAA_5555, 63'h5555_5555_5555_5555);
        send_power('0, 63'd5);
        // Modulus one: exponent zero gives 1, otherwise 0.
        write_modulus(31'd1);
        send_power(32'd7, '0);
        send_power(32'd7, 63'd3);
        send_power('1, '1);
        // Largest modulus.
        write_modulus(31'h7FFF_FFFF);
        send_power('1, '1);
        send_power(32'h7FFF_FFFE, 63'd2);
        send_power(32'h8000_0000, 63'd1);
        // Modulus zero, reachable through the port.
        write_modulus('0);
        send_power(32'd3, 63'd4);
        send_power(32'd3, '0);

        // Random phases over several moduli; one long receiver hold-off.
        foreach (moduli[k]) begin
            write_modulus(k == 5 ? 31'($urandom) : moduli[k]);
            if (k == 3) hold_req = 1'b1;
            if (k == 5) idle_off = 1'b1;
            repeat (21) send_power(rand_base(), rand_exponent());
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
